### hw/rtl/depth_pixel_backprojection_assert.svh
// Assertion macros for the depth pixel back-projection block.
// Expects signals named clock and reset in the including module.
`ifndef DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_ASSERT_SVH

// same-cycle implication
`define DPBP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dpbp assertion failed");

// next-cycle implication
`define DPBP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dpbp assertion failed");

`endif

### hw/rtl/dpbp_pkg.sv
// Shared widths, register map and reset values for depth pixel back-projection.
// No dependencies.
`timescale 1ns / 1ps

package dpbp_pkg;

   localparam int REG_W       = 28;
   localparam int COORD_W     = 12;
   localparam int DEPTH_W     = 24;
   localparam int RATIO_FRAC  = 18;
   localparam int RATIO_QBITS = 31;
   localparam int ROOT_BITS   = 32;
   localparam int S_W         = 64;
   localparam int OUT_W       = 32;
   localparam int Z_OUT_W     = 31;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 4;

   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;

   localparam logic [REG_W-1:0] FOCAL_X_RST  = 28'd40108032;
   localparam logic [REG_W-1:0] FOCAL_Y_RST  = 28'd40108032;
   localparam logic [REG_W-1:0] CENTER_X_RST = 28'd41786370;
   localparam logic [REG_W-1:0] CENTER_Y_RST = 28'd24202530;

   typedef enum logic [1:0] {
      IDX_FOCAL_X  = 2'd0,
      IDX_FOCAL_Y  = 2'd1,
      IDX_CENTER_X = 2'd2,
      IDX_CENTER_Y = 2'd3
   } csr_idx_type;

endpackage

### hw/rtl/dpbp_div_cell.sv
// One restoring-division cell: one quotient bit per cell, payload rides along.
// No dependencies.
`timescale 1ns / 1ps

module dpbp_div_cell #(
   parameter int DW = 28,
   parameter int QW = 31,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [DW-1:0] up_rem,
   input  logic          up_bit,
   input  logic [QW-1:0] up_quo,
   input  logic [DW-1:0] divisor,
   input  logic [PW-1:0] up_pay,
   output logic [DW-1:0] dn_rem,
   output logic [QW-1:0] dn_quo,
   output logic [PW-1:0] dn_pay
);

   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;
   logic [DW-1:0] rem_in, rem_ff;
   logic [QW-1:0] quo_in, quo_ff;
   logic [PW-1:0] pay_ff;

   assign trial  = {up_rem, up_bit};
   assign diff   = trial - {1'b0, divisor};
   assign ge     = trial >= {1'b0, divisor};
   assign rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
   assign quo_in = {up_quo[QW-2:0], ge};

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         pay_ff <= up_pay;
      end
   end

   assign dn_rem = rem_ff;
   assign dn_quo = quo_ff;
   assign dn_pay = pay_ff;

endmodule

### hw/rtl/dpbp_root_cell.sv
// One digit-by-digit square root cell: two radicand bits in, one root bit out.
// No dependencies.
`timescale 1ns / 1ps

module dpbp_root_cell #(
   parameter int RW = 32,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [RW-1:0] up_root,
   input  logic [RW+1:0] up_rem,
   input  logic [1:0]    up_pair,
   input  logic [PW-1:0] up_pay,
   output logic [RW-1:0] dn_root,
   output logic [RW+1:0] dn_rem,
   output logic [PW-1:0] dn_pay
);

   logic [RW+3:0] trial;
   logic [RW+3:0] cand;
   logic [RW+3:0] diff;
   logic          ge;
   logic [RW-1:0] root_in, root_ff;
   logic [RW+1:0] rem_in, rem_ff;
   logic [PW-1:0] pay_ff;

   assign trial   = {up_rem, up_pair};
   assign cand    = {2'b00, up_root, 2'b01};
   assign diff    = trial - cand;
   assign ge      = trial >= cand;
   assign rem_in  = ge ? diff[RW+1:0] : trial[RW+1:0];
   assign root_in = {up_root[RW-2:0], ge};

   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff <= root_in;
         rem_ff  <= rem_in;
         pay_ff  <= up_pay;
      end
   end

   assign dn_root = root_ff;
   assign dn_rem  = rem_ff;
   assign dn_pay  = pay_ff;

endmodule

### hw/rtl/depth_pixel_backprojection.sv
// Top level of depth pixel back-projection: CSR block, front stage, cell chains, output.
// Depends on dpbp_pkg, dpbp_div_cell, dpbp_root_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "depth_pixel_backprojection_assert.svh"

// Usage:
//   req_* carries one depth pixel per beat (col, row, depth, depth_valid).
//   rsp_* carries one 3-D point per beat for every pixel with depth_valid set;
//   pixels without it are taken and produce nothing.
//   csr_* is an APB-style port holding focal_x, focal_y, center_x, center_y
//   at byte offsets 0, 4, 8, 12; write it only while no pixel is in flight.
// Path: 92 stages, the first loaded at the edge that takes its pixel: a front stage,
//   31 ratio-division cells, square and sum stages, 32 square root cells,
//   24 depth-division cells, a multiply stage and the output register.
// Throughput: one pixel per cycle unless stalled; every cell moves one beat per cycle.
// Stall: when rsp_ready is low with a result waiting, the whole chain holds and
//   req_ready drops; it resumes the cycle the result is taken.
// Reset: synchronous; empties the chain and loads the default intrinsics.

module depth_pixel_backprojection
   import dpbp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [COORD_W-1:0]       req_col,
   input  logic [COORD_W-1:0]       req_row,
   input  logic [DEPTH_W-1:0]       req_depth,
   input  logic                     req_depth_valid,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [OUT_W-1:0]  rsp_point_x,
   output logic signed [OUT_W-1:0]  rsp_point_y,
   output logic [Z_OUT_W-1:0]       rsp_point_z,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [ADDR_W-1:0]        csr_paddr,
   input  logic [DATA_W-1:0]        csr_pwdata,
   output logic [DATA_W-1:0]        csr_prdata,
   output logic                     csr_pready
);

   localparam int CW     = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
   localparam int MAG_W  = (CW + FRAC_BITS > REG_W) ? CW + FRAC_BITS : REG_W;
   localparam int OVF_SH = RATIO_QBITS - RATIO_FRAC;
   localparam int CMP_W  = (MAG_W > REG_W + OVF_SH) ? MAG_W : REG_W + OVF_SH;
   localparam int RQ     = RATIO_QBITS;
   localparam int ZB     = DEPTH_W;
   localparam int SQ_W   = 2 * RATIO_QBITS;
   localparam int XM_W   = RATIO_QBITS + ZB;
   localparam int XS_W   = XM_W - RATIO_FRAC;
   localparam int PWA    = MAG_W + 2 + DEPTH_W;
   localparam int PWB    = MAG_W + 2;
   localparam int AB_W   = 2 * (RATIO_QBITS + 1);
   localparam int PR     = S_W + DEPTH_W + AB_W;
   localparam int PZ     = ROOT_BITS + DEPTH_W + AB_W;
   localparam int NST    = 1 + RQ + 2 + ROOT_BITS + ZB + 2;
   localparam int P_RT_END = RQ + 2 + ROOT_BITS;
   localparam int P_Z_END  = P_RT_END + ZB;
   localparam logic [S_W-1:0] S_ONE = S_W'(1) << (2 * RATIO_FRAC);
   localparam logic [RATIO_QBITS-1:0] RATIO_MAX = '1;
   localparam logic [XS_W-1:0] POS_MAX = XS_W'({1'b0, {(OUT_W-1){1'b1}}});
   localparam logic [XS_W-1:0] NEG_MAX = XS_W'({1'b1, {(OUT_W-1){1'b0}}});

   function automatic logic [OUT_W-1:0] sat_coord(input logic [XS_W-1:0] mag,
                                                 input logic neg);
      logic [OUT_W-1:0] res;
      if (neg) begin
         if (mag > NEG_MAX) res = NEG_MAX[OUT_W-1:0];
         else res = OUT_W'(XS_W'(0) - mag);
      end else begin
         if (mag > POS_MAX) res = POS_MAX[OUT_W-1:0];
         else res = mag[OUT_W-1:0];
      end
      return res;
   endfunction

   // ---------------- CSR ----------------
   logic [REG_W-1:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic             csr_wr;
   csr_idx_type      csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_idx_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FOCAL_X_RST;
         focal_y_ff  <= FOCAL_Y_RST;
         center_x_ff <= CENTER_X_RST;
         center_y_ff <= CENTER_Y_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            IDX_FOCAL_X:  focal_x_ff  <= csr_pwdata[REG_W-1:0];
            IDX_FOCAL_Y:  focal_y_ff  <= csr_pwdata[REG_W-1:0];
            IDX_CENTER_X: center_x_ff <= csr_pwdata[REG_W-1:0];
            IDX_CENTER_Y: center_y_ff <= csr_pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         IDX_FOCAL_X:  csr_prdata = DATA_W'(focal_x_ff);
         IDX_FOCAL_Y:  csr_prdata = DATA_W'(focal_y_ff);
         IDX_CENTER_X: csr_prdata = DATA_W'(center_x_ff);
         IDX_CENTER_Y: csr_prdata = DATA_W'(center_y_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic             adv;
   logic [NST-1:0]   vld_ff;

   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid && req_depth_valid};
      end
   end

   // ---------------- front stage ----------------
   logic [REG_W-1:0] fx, fy;
   logic [MAG_W-1:0] pos_a, pos_b, cen_a, cen_b;
   logic [MAG_W-1:0] fr_mag_a_in, fr_mag_b_in, fr_mag_a_ff, fr_mag_b_ff;
   logic             fr_neg_a_in, fr_neg_b_in, fr_neg_a_ff, fr_neg_b_ff;
   logic             fr_ovf_a_in, fr_ovf_b_in, fr_ovf_a_ff, fr_ovf_b_ff;
   logic [DEPTH_W-1:0] fr_depth_ff;

   assign fx    = (focal_x_ff == '0) ? REG_W'(1) : focal_x_ff;
   assign fy    = (focal_y_ff == '0) ? REG_W'(1) : focal_y_ff;
   assign pos_a = MAG_W'(req_col[CW-1:0]) << FRAC_BITS;
   assign pos_b = MAG_W'(req_row[CW-1:0]) << FRAC_BITS;
   assign cen_a = MAG_W'(center_x_ff);
   assign cen_b = MAG_W'(center_y_ff);
   assign fr_neg_a_in = cen_a < pos_a;
   assign fr_neg_b_in = cen_b < pos_b;
   assign fr_mag_a_in = fr_neg_a_in ? pos_a - cen_a : cen_a - pos_a;
   assign fr_mag_b_in = fr_neg_b_in ? pos_b - cen_b : cen_b - pos_b;
   assign fr_ovf_a_in = CMP_W'(fr_mag_a_in) >= (CMP_W'(fx) << OVF_SH);
   assign fr_ovf_b_in = CMP_W'(fr_mag_b_in) >= (CMP_W'(fy) << OVF_SH);

   always_ff @(posedge clock) begin
      if (adv) begin
         fr_mag_a_ff <= fr_mag_a_in;
         fr_mag_b_ff <= fr_mag_b_in;
         fr_neg_a_ff <= fr_neg_a_in;
         fr_neg_b_ff <= fr_neg_b_in;
         fr_ovf_a_ff <= fr_ovf_a_in;
         fr_ovf_b_ff <= fr_ovf_b_in;
         fr_depth_ff <= req_depth;
      end
   end

   // ---------------- ratio division chain ----------------
   logic [REG_W-1:0] ra_rem [0:RQ];
   logic [RQ-1:0]    ra_quo [0:RQ];
   logic [PWA-1:0]   ra_pay [0:RQ];
   logic [REG_W-1:0] rb_rem [0:RQ];
   logic [RQ-1:0]    rb_quo [0:RQ];
   logic [PWB-1:0]   rb_pay [0:RQ];

   assign ra_rem[0] = REG_W'(CMP_W'(fr_mag_a_ff) >> OVF_SH);
   assign rb_rem[0] = REG_W'(CMP_W'(fr_mag_b_ff) >> OVF_SH);
   assign ra_quo[0] = '0;
   assign rb_quo[0] = '0;
   assign ra_pay[0] = {fr_depth_ff, fr_neg_a_ff, fr_ovf_a_ff, fr_mag_a_ff};
   assign rb_pay[0] = {fr_neg_b_ff, fr_ovf_b_ff, fr_mag_b_ff};

   for (genvar j = 0; j < RQ; j++) begin : g_ratio
      localparam int QI = RQ - 1 - j;
      logic bit_a, bit_b;
      if (QI >= RATIO_FRAC) begin : g_bit
         assign bit_a = ra_pay[j][QI-RATIO_FRAC];
         assign bit_b = rb_pay[j][QI-RATIO_FRAC];
      end else begin : g_zero
         assign bit_a = 1'b0;
         assign bit_b = 1'b0;
      end
      dpbp_div_cell #(.DW(REG_W), .QW(RQ), .PW(PWA)) u_cell_a (
         .clock(clock), .adv(adv), .up_rem(ra_rem[j]), .up_bit(bit_a),
         .up_quo(ra_quo[j]), .divisor(fx), .up_pay(ra_pay[j]),
         .dn_rem(ra_rem[j+1]), .dn_quo(ra_quo[j+1]), .dn_pay(ra_pay[j+1]));
      dpbp_div_cell #(.DW(REG_W), .QW(RQ), .PW(PWB)) u_cell_b (
         .clock(clock), .adv(adv), .up_rem(rb_rem[j]), .up_bit(bit_b),
         .up_quo(rb_quo[j]), .divisor(fy), .up_pay(rb_pay[j]),
         .dn_rem(rb_rem[j+1]), .dn_quo(rb_quo[j+1]), .dn_pay(rb_pay[j+1]));
   end

   // ---------------- square and sum ----------------
   logic [RQ-1:0]      sq_a_in, sq_b_in, sq_a_ff, sq_b_ff, su_a_ff, su_b_ff;
   logic               sq_na_in, sq_nb_in, sq_na_ff, sq_nb_ff, su_na_ff, su_nb_ff;
   logic [SQ_W-1:0]    sq_a2_ff, sq_b2_ff;
   logic [DEPTH_W-1:0] sq_depth_ff, su_depth_ff;
   logic [S_W-1:0]     su_s_ff;

   assign sq_a_in  = ra_pay[RQ][MAG_W] ? RATIO_MAX : ra_quo[RQ];
   assign sq_b_in  = rb_pay[RQ][MAG_W] ? RATIO_MAX : rb_quo[RQ];
   assign sq_na_in = ra_pay[RQ][MAG_W+1] && (sq_a_in != '0);
   assign sq_nb_in = rb_pay[RQ][MAG_W+1] && (sq_b_in != '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_a_ff     <= sq_a_in;
         sq_b_ff     <= sq_b_in;
         sq_na_ff    <= sq_na_in;
         sq_nb_ff    <= sq_nb_in;
         sq_a2_ff    <= SQ_W'(sq_a_in) * SQ_W'(sq_a_in);
         sq_b2_ff    <= SQ_W'(sq_b_in) * SQ_W'(sq_b_in);
         sq_depth_ff <= ra_pay[RQ][MAG_W+2 +: DEPTH_W];
         su_s_ff     <= S_ONE + S_W'(sq_a2_ff) + S_W'(sq_b2_ff);
         su_a_ff     <= sq_a_ff;
         su_b_ff     <= sq_b_ff;
         su_na_ff    <= sq_na_ff;
         su_nb_ff    <= sq_nb_ff;
         su_depth_ff <= sq_depth_ff;
      end
   end

   // ---------------- square root chain ----------------
   // payload: {s, depth, nb, b, na, a}
   logic [ROOT_BITS-1:0] rt_root [0:ROOT_BITS];
   logic [ROOT_BITS+1:0] rt_rem  [0:ROOT_BITS];
   logic [PR-1:0]        rt_pay  [0:ROOT_BITS];

   assign rt_root[0] = '0;
   assign rt_rem[0]  = '0;
   assign rt_pay[0]  = {su_s_ff, su_depth_ff, su_nb_ff, su_b_ff, su_na_ff, su_a_ff};

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
      localparam int PI = ROOT_BITS - 1 - j;
      dpbp_root_cell #(.RW(ROOT_BITS), .PW(PR)) u_cell (
         .clock(clock), .adv(adv), .up_root(rt_root[j]), .up_rem(rt_rem[j]),
         .up_pair(rt_pay[j][AB_W + DEPTH_W + 2*PI +: 2]), .up_pay(rt_pay[j]),
         .dn_root(rt_root[j+1]), .dn_rem(rt_rem[j+1]), .dn_pay(rt_pay[j+1]));
   end

   // ---------------- depth division chain ----------------
   // payload: {r, depth, nb, b, na, a}
   logic [ROOT_BITS-1:0] zd_rem [0:ZB];
   logic [ZB-1:0]        zd_quo [0:ZB];
   logic [PZ-1:0]        zd_pay [0:ZB];

   assign zd_pay[0] = {rt_root[ROOT_BITS], rt_pay[ROOT_BITS][AB_W+DEPTH_W-1:0]};
   assign zd_rem[0] = ROOT_BITS'(rt_pay[ROOT_BITS][AB_W +: DEPTH_W] >> (ZB - RATIO_FRAC));
   assign zd_quo[0] = '0;

   for (genvar j = 0; j < ZB; j++) begin : g_zdiv
      localparam int QI = ZB - 1 - j;
      logic nbit;
      if (QI >= RATIO_FRAC) begin : g_bit
         assign nbit = zd_pay[j][AB_W + QI - RATIO_FRAC];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
      dpbp_div_cell #(.DW(ROOT_BITS), .QW(ZB), .PW(PZ)) u_cell (
         .clock(clock), .adv(adv), .up_rem(zd_rem[j]), .up_bit(nbit),
         .up_quo(zd_quo[j]), .divisor(zd_pay[j][AB_W+DEPTH_W +: ROOT_BITS]),
         .up_pay(zd_pay[j]),
         .dn_rem(zd_rem[j+1]), .dn_quo(zd_quo[j+1]), .dn_pay(zd_pay[j+1]));
   end

   // ---------------- multiply and output ----------------
   logic [RQ-1:0]      zd_a, zd_b;
   logic [XM_W-1:0]    mu_xm_ff, mu_ym_ff;
   logic               mu_na_ff, mu_nb_ff;
   logic [ZB-1:0]      mu_z_ff;
   logic [OUT_W-1:0]   out_x_ff, out_y_ff;
   logic [Z_OUT_W-1:0] out_z_ff;

   assign zd_a = zd_pay[ZB][RQ-1:0];
   assign zd_b = zd_pay[ZB][RQ+1 +: RQ];

   always_ff @(posedge clock) begin
      if (adv) begin
         mu_xm_ff <= XM_W'(zd_a) * XM_W'(zd_quo[ZB]);
         mu_ym_ff <= XM_W'(zd_b) * XM_W'(zd_quo[ZB]);
         mu_na_ff <= zd_pay[ZB][RQ];
         mu_nb_ff <= zd_pay[ZB][2*RQ+1];
         mu_z_ff  <= zd_quo[ZB];
         out_x_ff <= sat_coord(mu_xm_ff[XM_W-1:RATIO_FRAC], mu_na_ff);
         out_y_ff <= sat_coord(mu_ym_ff[XM_W-1:RATIO_FRAC], mu_nb_ff);
         out_z_ff <= Z_OUT_W'(mu_z_ff);
      end
   end

   assign rsp_point_x = $signed(out_x_ff);
   assign rsp_point_y = $signed(out_y_ff);
   assign rsp_point_z = out_z_ff;

   // ---------------- assertions ----------------
   `DPBP_ASSERT_NXT(a_pixel_enters, req_valid && req_ready && req_depth_valid, vld_ff[0])
   `DPBP_ASSERT_NXT(a_stall_holds, !adv, $stable(vld_ff))
   `DPBP_ASSERT_IMP(a_root_floor, vld_ff[P_RT_END], rt_root[ROOT_BITS][ROOT_BITS-1:RATIO_FRAC] != '0)
   `DPBP_ASSERT_IMP(a_z_le_depth, vld_ff[P_Z_END], zd_quo[ZB] <= zd_pay[ZB][AB_W +: DEPTH_W])

endmodule
